// ----- design/bfq_pkg.sv -----
// ----------------------------------------------------------------------------
// bfq_pkg
// shared types and codes for the bounded fifo queue
// ----------------------------------------------------------------------------
`default_nettype none

package bfq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned CAP_W         = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd16;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_CHECK = 2'd1;
    localparam logic [1:0] CMD_PUSH  = 2'd2;
    localparam logic [1:0] CMD_POP   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value_in;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] value_out;
        logic               is_empty;
    } t_res_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_ctrl_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- design/bfq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfq_ctrl
// sequencer: accept an item, execute it, load the result register
// ----------------------------------------------------------------------------
`default_nettype none

module bfq_ctrl
    import bfq_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                // wait here while the previous result is still held
                if (!i_stat.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/bfq_datapath.sv -----
// ----------------------------------------------------------------------------
// bfq_datapath
// ring buffer storage, pointers, count, capacity register and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bfq_datapath
    import bfq_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    input  wire t_cmd_item        i_in_item,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_res_item             o_out_item
);

    localparam int unsigned PW = $clog2(MAX_DEPTH);
    localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [PW-1:0] LAST_IDX  = PW'(MAX_DEPTH - 1);
    localparam logic [LW-1:0] DEPTH_LIM = LW'(MAX_DEPTH);

    logic [31:0] r_mem [MAX_DEPTH];

    logic [PW-1:0]    r_head;
    logic [PW-1:0]    r_tail;
    logic [CW-1:0]    r_count;
    logic [CAP_W-1:0] r_cap;
    t_cmd_item        r_item;
    logic [1:0]       r_status;
    logic             r_pop_ok;
    logic [31:0]      r_rd_data;
    logic             r_out_valid;
    t_res_item        r_out_item;

    logic [LW-1:0] cap_ext;
    logic [LW-1:0] cap_eff;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] tail_inc;

    always_comb begin
        cap_ext  = LW'(r_cap);
        cap_eff  = (cap_ext > DEPTH_LIM) ? DEPTH_LIM : cap_ext;
        full     = LW'(r_count) >= cap_eff;
        empty    = (r_count == '0);
        do_push  = i_cmd.exec && (r_item.cmd == CMD_PUSH) && !full;
        do_pop   = i_cmd.exec && (r_item.cmd == CMD_POP) && !empty;
        head_inc = (r_head == LAST_IDX) ? '0 : r_head + PW'(1);
        tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + PW'(1);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_cap   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec && (r_item.cmd == CMD_CLEAR)) begin
                r_head  <= '0;
                r_tail  <= '0;
                r_count <= '0;
            end else if (do_push) begin
                r_tail  <= tail_inc;
                r_count <= r_count + CW'(1);
            end else if (do_pop) begin
                r_head  <= head_inc;
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= r_item.value_in;
        end
        if (do_pop) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // item capture and execute stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_item;
        end
        if (i_cmd.exec) begin
            r_pop_ok <= do_pop;
            if ((r_item.cmd == CMD_PUSH) && full) begin
                r_status <= ST_FULL;
            end else if ((r_item.cmd == CMD_POP) && empty) begin
                r_status <= ST_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_item.status    <= r_status;
            r_out_item.value_out <= r_pop_ok ? r_rd_data : '0;
            r_out_item.is_empty  <= empty;
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

`default_nettype wire

// ----- design/bounded_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// bounded_fifo_queue
// first-in first-out queue of signed 32-bit values with a settable capacity
// ----------------------------------------------------------------------------
// each command item clears the queue, checks for empty, pushes a value or pops
// the oldest value, and gives exactly one result item (status, popped value,
// empty flag). the usable capacity is the 7-bit configuration register,
// saturated to MAX_DEPTH; zero means always full. storage is a ring buffer of
// MAX_DEPTH words with one write and one registered read port. an item passes
// from acceptance to a loaded result through capture, execute (the memory
// access and pointer update) and load into the result register. a new item
// is accepted only once the last one is loaded; the result register lets the
// next item be taken while the last result still waits, and the load stage
// holds only if that result has not yet been taken. stored data is never
// cleared, so no clearing pass follows reset
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_fifo_queue
    import bfq_pkg::*;
#(
    parameter int unsigned MAX_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // command channel
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire t_cmd_item        i_in_item,
    // result channel
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output t_res_item             o_out_item,
    // capacity register write
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata
);

    // command and status between sequencer and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bfq_datapath #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
